@@ rtl/lcd_sync_timing_generator_top_assert.svh @@
// assertion macros for the lcd sync timing generator
// each macro takes a label, a reset, an antecedent, a consequent and a message
`ifndef LCD_SYNC_TIMING_GENERATOR_TOP_ASSERT_SVH
`define LCD_SYNC_TIMING_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LCDSTG_ASSERT_NOW(label, reset, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (reset) (cond) |-> (prop)) \
    else $error(msg);
// next-cycle implication
`define LCDSTG_ASSERT_NEXT(label, reset, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (reset) (cond) |=> (prop)) \
    else $error(msg);
`else
`define LCDSTG_ASSERT_NOW(label, reset, cond, prop, msg)
`define LCDSTG_ASSERT_NEXT(label, reset, cond, prop, msg)
`endif
`endif

@@ rtl/lcdstg_pkg.sv @@
package lcdstg_pkg;

  // configuration register file
  localparam int REG_W     = 12;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  typedef logic [REG_W-1:0]     reg_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // register indexes
  localparam reg_idx_t REG_LINE_TOTAL    = 3'd0;
  localparam reg_idx_t REG_HSYNC_WIDTH   = 3'd1;
  localparam reg_idx_t REG_H_BACK_PORCH  = 3'd2;
  localparam reg_idx_t REG_ACTIVE_WIDTH  = 3'd3;
  localparam reg_idx_t REG_FRAME_TOTAL   = 3'd4;
  localparam reg_idx_t REG_VSYNC_WIDTH   = 3'd5;
  localparam reg_idx_t REG_V_BACK_PORCH  = 3'd6;
  localparam reg_idx_t REG_ACTIVE_HEIGHT = 3'd7;

  // register reset values
  localparam reg_t RST_LINE_TOTAL    = 12'd525;
  localparam reg_t RST_HSYNC_WIDTH   = 12'd41;
  localparam reg_t RST_H_BACK_PORCH  = 12'd2;
  localparam reg_t RST_ACTIVE_WIDTH  = 12'd480;
  localparam reg_t RST_FRAME_TOTAL   = 12'd286;
  localparam reg_t RST_VSYNC_WIDTH   = 12'd10;
  localparam reg_t RST_V_BACK_PORCH  = 12'd2;
  localparam reg_t RST_ACTIVE_HEIGHT = 12'd272;

  // one timing sample
  typedef struct packed {
    logic vsync_n;
    logic hsync_n;
    logic data_enable;
    logic line_end;
    logic frame_end;
  } sync_t;

endpackage

@@ rtl/lcdstg_if.sv @@
// tick request channel
interface lcdstg_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// timing sample channel
interface lcdstg_sync_if;
  logic valid;
  logic ready;
  logic vsync_n;
  logic hsync_n;
  logic data_enable;
  logic line_end;
  logic frame_end;
  modport source (output valid, output vsync_n, output hsync_n, output data_enable,
                  output line_end, output frame_end, input ready);
  modport sink   (input valid, input vsync_n, input hsync_n, input data_enable,
                  input line_end, input frame_end, output ready);
endinterface

// configuration write channel
interface lcdstg_cfg_if import lcdstg_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_idx_t index;
  reg_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lcd_sync_timing_generator_top.sv @@
// output: a sample appears on timing in the cycle after its tick request is taken
// throughput: one request per cycle; the position advance and window compares
//   are combinational, and a new request is taken in the same cycle the
//   previous sample leaves, so input stalls only while a sample waits at the output
// reset: rst is synchronous, active high; counters clear, registers take defaults
`include "lcd_sync_timing_generator_top_assert.svh"

module lcd_sync_timing_generator_top import lcdstg_pkg::*; #(
  parameter int COUNT_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  lcdstg_tick_if.sink   step,
  lcdstg_sync_if.source timing,
  lcdstg_cfg_if.sink    cfg
);

  // compare width holds position + 1 and porch + count without loss
  localparam int CMP_W = ((COUNT_BITS > REG_W) ? COUNT_BITS : REG_W) + 1;

  typedef logic [CMP_W-1:0] cmp_t;

  reg_t line_total, hsync_width, h_back_porch, active_width;
  reg_t frame_total, vsync_width, v_back_porch, active_height;

  logic [COUNT_BITS-1:0] h_position, v_position;
  logic [COUNT_BITS-1:0] h_position_next, v_position_next;

  sync_t result, sample;
  logic  out_valid;
  logic  accept;

  cmp_t h_ext, v_ext, h_inc, v_inc;
  logic active_line, active_clk, last_clk, last_line;

  // configuration writes, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_total    <= RST_LINE_TOTAL;
      hsync_width   <= RST_HSYNC_WIDTH;
      h_back_porch  <= RST_H_BACK_PORCH;
      active_width  <= RST_ACTIVE_WIDTH;
      frame_total   <= RST_FRAME_TOTAL;
      vsync_width   <= RST_VSYNC_WIDTH;
      v_back_porch  <= RST_V_BACK_PORCH;
      active_height <= RST_ACTIVE_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LINE_TOTAL:    line_total    <= cfg.data;
        REG_HSYNC_WIDTH:   hsync_width   <= cfg.data;
        REG_H_BACK_PORCH:  h_back_porch  <= cfg.data;
        REG_ACTIVE_WIDTH:  active_width  <= cfg.data;
        REG_FRAME_TOTAL:   frame_total   <= cfg.data;
        REG_VSYNC_WIDTH:   vsync_width   <= cfg.data;
        REG_V_BACK_PORCH:  v_back_porch  <= cfg.data;
        REG_ACTIVE_HEIGHT: active_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // request handshake: take a new tick unless a sample is stuck at the output
  assign step.ready = !out_valid || timing.ready;
  assign accept     = step.valid && step.ready;

  // window compares at the current position
  always_comb begin
    h_ext = cmp_t'(h_position);
    v_ext = cmp_t'(v_position);
    h_inc = h_ext + cmp_t'(1);
    v_inc = v_ext + cmp_t'(1);

    active_line = (v_ext >= cmp_t'(v_back_porch)) &&
                  (v_ext < (cmp_t'(v_back_porch) + cmp_t'(active_height)));
    active_clk  = (h_ext >= cmp_t'(h_back_porch)) &&
                  (h_ext < (cmp_t'(h_back_porch) + cmp_t'(active_width)));
    last_clk    = h_inc >= cmp_t'(line_total);
    last_line   = v_inc >= cmp_t'(frame_total);

    result.vsync_n     = !(v_ext < cmp_t'(vsync_width));
    result.hsync_n     = !(h_ext < cmp_t'(hsync_width));
    result.data_enable = active_line && active_clk;
    result.line_end    = last_clk;
    result.frame_end   = last_clk && last_line;
  end

  // position advance, wrapping at the totals
  always_comb begin
    h_position_next = h_position;
    v_position_next = v_position;
    if (step.tick) begin
      if (last_clk) begin
        h_position_next = '0;
        v_position_next = last_line ? '0 : v_inc[COUNT_BITS-1:0];
      end else begin
        h_position_next = h_inc[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_position <= '0;
      v_position <= '0;
    end else if (accept) begin
      h_position <= h_position_next;
      v_position <= v_position_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (timing.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= result;
    end
  end

  assign timing.valid       = out_valid;
  assign timing.vsync_n     = sample.vsync_n;
  assign timing.hsync_n     = sample.hsync_n;
  assign timing.data_enable = sample.data_enable;
  assign timing.line_end    = sample.line_end;
  assign timing.frame_end   = sample.frame_end;

  // checks
  `LCDSTG_ASSERT_NEXT(a_accept_gives_sample, rst, accept, out_valid,
    "accepted request left no sample")
  `LCDSTG_ASSERT_NEXT(a_line_wrap, rst, accept && step.tick && last_clk, h_position == '0,
    "line did not wrap after its last clock")
  `LCDSTG_ASSERT_NEXT(a_frame_wrap, rst, accept && step.tick && last_clk && last_line,
    v_position == '0, "frame did not wrap after its last clock")
  `LCDSTG_ASSERT_NEXT(a_hold_without_tick, rst, accept && !step.tick,
    $stable(h_position) && $stable(v_position), "position moved without a tick")
  `LCDSTG_ASSERT_NOW(a_frame_end_on_line_end, rst, out_valid,
    !timing.frame_end || timing.line_end, "frame end without line end")

endmodule

@@ tb/lcdstg_sync_checker.sv @@
// watches the tick, timing and register channels, predicts every timing sample
// and compares it with what the generator returns
module lcdstg_sync_checker import lcdstg_pkg::*; #(
  parameter int COUNT_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  lcdstg_tick_if        step,
  lcdstg_sync_if        timing,
  lcdstg_cfg_if         cfg,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the timing registers and the position counters
  reg_t                  timing_regs [NUM_REGS];
  logic [COUNT_BITS-1:0] h_pos;
  logic [COUNT_BITS-1:0] v_pos;

  // samples predicted for accepted tick requests, oldest first
  sync_t sample_q [$];

  string field_names [5] = '{"frame_end", "line_end", "data_enable", "hsync_n", "vsync_n"};

  task automatic report_mismatch(input string msg);
    $display("%0t ns  timing check: %s", $time, msg);
    fail_count++;
  endtask

  // start <= pos < start + len, sum formed without truncation
  function automatic logic in_span(input int pos, input reg_t start, input reg_t len);
    return (pos >= int'(start)) && (pos < int'(start) + int'(len));
  endfunction

  // sample for the current position, then advance when the request carries a tick
  function automatic sync_t predict_sample(input logic adv);
    sync_t s;
    int    h;
    int    v;
    logic  last_clk;
    logic  last_line;
    h         = int'(h_pos);
    v         = int'(v_pos);
    last_clk  = (h + 1) >= int'(timing_regs[REG_LINE_TOTAL]);
    last_line = (v + 1) >= int'(timing_regs[REG_FRAME_TOTAL]);
    s.vsync_n     = !(v < int'(timing_regs[REG_VSYNC_WIDTH]));
    s.hsync_n     = !(h < int'(timing_regs[REG_HSYNC_WIDTH]));
    s.data_enable = in_span(v, timing_regs[REG_V_BACK_PORCH], timing_regs[REG_ACTIVE_HEIGHT]) &&
                    in_span(h, timing_regs[REG_H_BACK_PORCH], timing_regs[REG_ACTIVE_WIDTH]);
    s.line_end    = last_clk;
    s.frame_end   = last_clk && last_line;
    if (adv) begin
      if (last_clk) begin
        h_pos = '0;
        v_pos = last_line ? '0 : COUNT_BITS'(v + 1);
      end else begin
        h_pos = COUNT_BITS'(h + 1);
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    sync_t exp_s;
    sync_t got_s;
    if (rst) begin
      timing_regs[REG_LINE_TOTAL]    = RST_LINE_TOTAL;
      timing_regs[REG_HSYNC_WIDTH]   = RST_HSYNC_WIDTH;
      timing_regs[REG_H_BACK_PORCH]  = RST_H_BACK_PORCH;
      timing_regs[REG_ACTIVE_WIDTH]  = RST_ACTIVE_WIDTH;
      timing_regs[REG_FRAME_TOTAL]   = RST_FRAME_TOTAL;
      timing_regs[REG_VSYNC_WIDTH]   = RST_VSYNC_WIDTH;
      timing_regs[REG_V_BACK_PORCH]  = RST_V_BACK_PORCH;
      timing_regs[REG_ACTIVE_HEIGHT] = RST_ACTIVE_HEIGHT;
      h_pos = '0;
      v_pos = '0;
      sample_q.delete();
    end else begin
      // register write
      if (cfg.valid && cfg.ready) begin
        timing_regs[cfg.index] = cfg.data;
      end
      // tick request taken
      if (step.valid && step.ready) begin
        sample_q.push_back(predict_sample(step.tick));
      end
      // timing sample returned
      if (timing.valid && timing.ready) begin
        got_s = {timing.vsync_n, timing.hsync_n, timing.data_enable,
                 timing.line_end, timing.frame_end};
        if (sample_q.size() == 0) begin
          report_mismatch("timing sample with no tick request outstanding");
        end else begin
          exp_s = sample_q.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (got_s[i] !== exp_s[i]) begin
              report_mismatch($sformatf("%s expected %b got %b",
                                        field_names[i], exp_s[i], got_s[i]));
            end
          end
        end
      end
    end
    pending <= sample_q.size();
  end

endmodule

@@ tb/tb_lcd_sync_timing_generator_top.sv @@
module tb_lcd_sync_timing_generator_top;
  import lcdstg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 50;
  localparam int RANDOM_PHASES   = 26;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 200000;

  logic clk;
  logic rst;

  lcdstg_tick_if step_ch ();
  lcdstg_sync_if timing_ch ();
  lcdstg_cfg_if  cfg_ch ();

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_go;
  int hold_cnt;
  int cycle_cnt = 0;

  lcd_sync_timing_generator_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .step   (step_ch),
    .timing (timing_ch),
    .cfg    (cfg_ch)
  );

  lcdstg_sync_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .step       (step_ch),
    .timing     (timing_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lcd_sync_timing_generator_top: mismatch");
      $finish;
    end
  end

  // timing sink: random stalls plus one long hold-off when requested
  initial begin
    timing_ch.ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
        timing_ch.ready <= 1'b0;
        hold_cnt = hold_cnt + 1;
      end else begin
        timing_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one tick request, with random idle cycles ahead of it
  task automatic send_tick(input logic adv);
    while ($urandom_range(99) < send_idle_pct) begin
      step_ch.valid <= 1'b0;
      @(posedge clk);
    end
    step_ch.valid <= 1'b1;
    step_ch.tick  <= adv;
    do @(posedge clk); while (!step_ch.ready);
  endtask

  // stop requesting and wait for every outstanding sample
  task automatic wait_idle();
    step_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write one register; valid stays up for back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input reg_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_timing(input reg_t lt, input reg_t hw, input reg_t hbp, input reg_t aw,
                            input reg_t ft, input reg_t vw, input reg_t vbp, input reg_t ah);
    wait_idle();
    write_reg(REG_LINE_TOTAL, lt);
    write_reg(REG_HSYNC_WIDTH, hw);
    write_reg(REG_H_BACK_PORCH, hbp);
    write_reg(REG_ACTIVE_WIDTH, aw);
    write_reg(REG_FRAME_TOTAL, ft);
    write_reg(REG_VSYNC_WIDTH, vw);
    write_reg(REG_V_BACK_PORCH, vbp);
    write_reg(REG_ACTIVE_HEIGHT, ah);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // totals: mostly short so lines and frames wrap often
  function automatic reg_t pick_total(input int small_max);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return reg_t'($urandom_range(4095));
      default: return reg_t'($urandom_range(1, small_max));
    endcase
  endfunction

  // sync widths, porches and active counts around the total
  function automatic reg_t pick_span(input reg_t total);
    int t;
    t = int'(total);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return reg_t'($urandom_range(4095));
      default: return reg_t'($urandom_range(0, (t > 4093) ? 4095 : t + 2));
    endcase
  endfunction

  initial begin
    reg_t lt;
    reg_t ft;
    rst              = 1'b1;
    step_ch.valid    = 1'b0;
    step_ch.tick     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_LINE_TOTAL;
    cfg_ch.data      = '0;
    send_idle_pct    = 19;
    recv_idle_pct    = 54;
    hold_go          = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: report-only and advancing requests
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);

    // tiny frame; position already past the new line total
    set_timing(12'd3, 12'd1, 12'd1, 12'd2, 12'd3, 12'd1, 12'd1, 12'd1);
    for (int i = 0; i < 12; i++) send_tick((i % 5) != 3);

    // zero totals act as one: every clock ends a line and a frame
    set_timing(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);

    // largest totals, porch plus active runs past the total
    set_timing(12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // random timings, phases of sender-heavy, receiver-heavy and no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      lt = pick_total(16);
      ft = pick_total(8);
      set_timing(lt, pick_span(lt), pick_span(lt), pick_span(lt),
                 ft, pick_span(ft), pick_span(ft), pick_span(ft));
      if (p < RANDOM_PHASES / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 54;
      end else if (p < 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold-off while requests keep coming
      if (p == RANDOM_PHASES - 4) hold_go = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_tick($urandom_range(99) < 85);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("lcd_sync_timing_generator_top: match");
    end else begin
      $display("lcd_sync_timing_generator_top: mismatch");
    end
    $finish;
  end

endmodule
